/* hdl/svm_pkg.sv */
`default_nettype none
package svm_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_DEFINE = 2'd1,
        FUNC_PLAY   = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PST_NONE    = 2'd0,
        PST_STARTED = 2'd1,
        PST_PLAYING = 2'd2,
        PST_NO_VOICE = 2'd3
    } play_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_DEFINE,
        ST_PLAY,
        ST_V_TBL,
        ST_V_ADDR,
        ST_V_MEM,
        ST_V_ACC,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam int unsigned MAX_CLIP_LEN = 4096;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch input word
        logic do_write;    // write sample memory
        logic do_define;   // write clip table
        logic do_play;     // allocate a voice
        logic voice_clear; // reset voice index and accumulators
        logic tbl_read;    // register clip table entry for current voice
        logic addr_calc;   // register sample address
        logic mem_read;    // register sample byte
        logic acc;         // accumulate and advance voice
        logic voice_next;  // step voice index
        logic div_init;    // load divider
        logic div_step;    // one quotient bit
        logic finish;      // present result
    } cmd_t;

    typedef struct packed {
        logic  cur_active; // current voice is active
        logic  last_voice; // current voice is the last one
        logic  div_done;   // divider finished
        func_t func;       // captured function
    } sts_t;

endpackage
`default_nettype wire

/* hdl/sample_voice_mixer_unit.sv */
`default_nettype none
// A write word steps through capture, write and done; define and play add their table or
// voice step before done. A tick walks each voice (table, address, memory, accumulate
// when active; an idle voice goes straight on to the next), then runs the
// one-bit-per-cycle divider, which is skipped when no voice was active.
// Busy drops as done rises, so a new word is taken only once the last one is done.
// Reset (rst_n low, asynchronous) frees all voices; sample and clip memories hold.
module sample_voice_mixer_unit #(
    parameter int VOICES       = 4,
    parameter int CLIPS        = 16,
    parameter int SAMPLE_WORDS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic [1:0]  func,
    input  wire logic [11:0] mem_addr,
    input  wire logic [7:0]  mem_data,
    input  wire logic [3:0]  clip_id,
    input  wire logic [11:0] clip_start,
    input  wire logic [12:0] clip_length,
    output logic             level_valid,
    output logic [7:0]       level,
    output logic [1:0]       play_status
);

    // command and status between sequencer and datapath
    svm_pkg::cmd_t cmd;
    svm_pkg::sts_t sts;

    svm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    svm_dp #(
        .VOICES       (VOICES),
        .CLIPS        (CLIPS),
        .SAMPLE_WORDS (SAMPLE_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .mem_addr    (mem_addr),
        .mem_data    (mem_data),
        .clip_id     (clip_id),
        .clip_start  (clip_start),
        .clip_length (clip_length),
        .level_valid (level_valid),
        .level       (level),
        .play_status (play_status),
        .done        (done)
    );

endmodule
`default_nettype wire

/* hdl/svm_ctrl.sv */
`default_nettype none
module svm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output svm_pkg::cmd_t       cmd,
    input  wire svm_pkg::sts_t  sts
);

    svm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svm_pkg::ST_IDLE:
                if (start) state_next = svm_pkg::ST_WRITE;
            svm_pkg::ST_WRITE:
            begin
                unique case (sts.func)
                    svm_pkg::FUNC_WRITE:  state_next = svm_pkg::ST_DONE;
                    svm_pkg::FUNC_DEFINE: state_next = svm_pkg::ST_DEFINE;
                    svm_pkg::FUNC_PLAY:   state_next = svm_pkg::ST_PLAY;
                    default:              state_next = svm_pkg::ST_V_TBL;
                endcase
            end
            svm_pkg::ST_DEFINE: state_next = svm_pkg::ST_DONE;
            svm_pkg::ST_PLAY:   state_next = svm_pkg::ST_DONE;
            svm_pkg::ST_V_TBL:
            begin
                if (sts.cur_active)   state_next = svm_pkg::ST_V_ADDR;
                else if (sts.last_voice) state_next = svm_pkg::ST_DIV;
                else                  state_next = svm_pkg::ST_V_TBL;
            end
            svm_pkg::ST_V_ADDR: state_next = svm_pkg::ST_V_MEM;
            svm_pkg::ST_V_MEM:  state_next = svm_pkg::ST_V_ACC;
            svm_pkg::ST_V_ACC:
                state_next = sts.last_voice ? svm_pkg::ST_DIV : svm_pkg::ST_V_TBL;
            svm_pkg::ST_DIV:
                if (sts.div_done) state_next = svm_pkg::ST_DONE;
            svm_pkg::ST_DONE:   state_next = svm_pkg::ST_IDLE;
            default:            state_next = svm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != svm_pkg::ST_IDLE);
        unique case (state_reg)
            svm_pkg::ST_IDLE:   cmd.capture = start;
            svm_pkg::ST_WRITE:
            begin
                cmd.do_write    = (sts.func == svm_pkg::FUNC_WRITE);
                cmd.voice_clear = 1'b1;
            end
            svm_pkg::ST_DEFINE: cmd.do_define = 1'b1;
            svm_pkg::ST_PLAY:   cmd.do_play = 1'b1;
            svm_pkg::ST_V_TBL:
            begin
                cmd.tbl_read   = sts.cur_active;
                cmd.voice_next = !sts.cur_active && !sts.last_voice;
                cmd.div_init   = !sts.cur_active && sts.last_voice;
            end
            svm_pkg::ST_V_ADDR: cmd.addr_calc = 1'b1;
            svm_pkg::ST_V_MEM:  cmd.mem_read = 1'b1;
            svm_pkg::ST_V_ACC:
            begin
                cmd.acc        = 1'b1;
                cmd.voice_next = !sts.last_voice;
                cmd.div_init   = sts.last_voice;
            end
            svm_pkg::ST_DIV:    cmd.div_step = !sts.div_done;
            svm_pkg::ST_DONE:   cmd.finish = 1'b1;
            default:            cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/svm_dp.sv */
`default_nettype none
module svm_dp #(
    parameter int VOICES       = 4,
    parameter int CLIPS        = 16,
    parameter int SAMPLE_WORDS = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire svm_pkg::cmd_t  cmd,
    output svm_pkg::sts_t       sts,
    input  wire logic [1:0]     func,
    input  wire logic [11:0]    mem_addr,
    input  wire logic [7:0]     mem_data,
    input  wire logic [3:0]     clip_id,
    input  wire logic [11:0]    clip_start,
    input  wire logic [12:0]    clip_length,
    output logic                level_valid,
    output logic [7:0]          level,
    output logic [1:0]          play_status,
    output logic                done
);

    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int CW = (CLIPS > 1) ? $clog2(CLIPS) : 1;
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NW = $clog2(VOICES + 1);
    localparam int SW = 8 + NW;

    // captured word
    svm_pkg::func_t func_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [3:0]  clip_reg;
    logic [11:0] cstart_reg;
    logic [12:0] clen_reg;

    logic [7:0]  sample_mem [SAMPLE_WORDS];
    logic [11:0] start_tbl [CLIPS];
    logic [12:0] len_tbl [CLIPS];

    logic [VOICES-1:0] act_reg;
    logic [3:0]  vclip_reg [VOICES];
    logic [11:0] vpos_reg [VOICES];

    logic [VW-1:0] vi_reg;
    logic [11:0]   tstart_reg;
    logic [12:0]   tlen_reg;
    logic [AW-1:0] saddr_reg;
    logic [7:0]    samp_reg;
    logic [SW-1:0] sum_reg;
    logic [NW-1:0] cnt_reg;

    // restoring divider
    logic [SW-1:0] quo_reg;
    logic [NW-1:0] rem_reg;
    logic [$clog2(SW+1)-1:0] dcnt_reg;

    logic        lvalid_reg;
    logic [7:0]  level_reg;
    logic [1:0]  pst_reg;
    logic        done_reg;

    logic [VW-1:0] free_idx;
    logic          free_any;
    logic          dup;
    logic [CW-1:0] cur_clip;
    logic [12:0]   eff_len;
    logic [NW:0]   rem_shift;
    logic          div_ok;
    logic [SW+7:0] mean_full;

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        dup      = 1'b0;
        for (int v = VOICES - 1; v >= 0; v--)
        begin
            if (!act_reg[v])
            begin
                free_idx = VW'(v);
                free_any = 1'b1;
            end
        end
        for (int v = 0; v < VOICES; v++)
        begin
            if (act_reg[v] && vclip_reg[v] == clip_reg) dup = 1'b1;
        end
    end

    // out-of-range clip numbers can only read as clip 0
    assign cur_clip = (32'(vclip_reg[vi_reg]) >= CLIPS) ? '0 : CW'(vclip_reg[vi_reg]);
    always_comb
    begin
        eff_len = tlen_reg;
        if (eff_len == '0) eff_len = 13'd1;
        if (eff_len > 13'(svm_pkg::MAX_CLIP_LEN)) eff_len = 13'(svm_pkg::MAX_CLIP_LEN);
    end

    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign div_ok    = rem_shift >= {1'b0, cnt_reg};
    assign mean_full = {8'd0, quo_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= svm_pkg::func_t'(func);
            addr_reg   <= mem_addr;
            data_reg   <= mem_data;
            clip_reg   <= clip_id;
            cstart_reg <= clip_start;
            clen_reg   <= clip_length;
        end
        if (cmd.do_write) sample_mem[AW'(addr_reg)] <= data_reg;
        if (cmd.do_define && 32'(clip_reg) < CLIPS)
        begin
            start_tbl[CW'(clip_reg)] <= cstart_reg;
            len_tbl[CW'(clip_reg)]   <= clen_reg;
        end
        if (cmd.tbl_read)
        begin
            tstart_reg <= start_tbl[cur_clip];
            tlen_reg   <= len_tbl[cur_clip];
        end
        if (cmd.addr_calc) saddr_reg <= AW'(tstart_reg + vpos_reg[vi_reg]);
        if (cmd.mem_read)  samp_reg <= sample_mem[saddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= '0;
            for (int v = 0; v < VOICES; v++)
            begin
                vclip_reg[v] <= '0;
                vpos_reg[v]  <= '0;
            end
            vi_reg     <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            dcnt_reg   <= '0;
            lvalid_reg <= 1'b0;
            level_reg  <= '0;
            pst_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.capture) pst_reg <= svm_pkg::PST_NONE;
            if (cmd.voice_clear)
            begin
                vi_reg  <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.do_play)
            begin
                if (32'(clip_reg) >= CLIPS) pst_reg <= svm_pkg::PST_NO_VOICE;
                else if (dup)              pst_reg <= svm_pkg::PST_PLAYING;
                else if (!free_any)        pst_reg <= svm_pkg::PST_NO_VOICE;
                else
                begin
                    pst_reg            <= svm_pkg::PST_STARTED;
                    act_reg[free_idx]  <= 1'b1;
                    vclip_reg[free_idx] <= clip_reg;
                    vpos_reg[free_idx] <= '0;
                end
            end
            if (cmd.acc)
            begin
                sum_reg <= sum_reg + SW'(samp_reg);
                cnt_reg <= cnt_reg + NW'(1);
                if ({1'b0, vpos_reg[vi_reg]} >= eff_len - 13'd1)
                begin
                    act_reg[vi_reg]  <= 1'b0;
                    vpos_reg[vi_reg] <= '0;
                end
                else
                begin
                    vpos_reg[vi_reg] <= vpos_reg[vi_reg] + 12'd1;
                end
            end
            if (cmd.voice_next) vi_reg <= vi_reg + VW'(1);
            if (cmd.div_init)
            begin
                // last accumulate may land in this same cycle
                quo_reg  <= cmd.acc ? sum_reg + SW'(samp_reg) : sum_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                quo_reg  <= {quo_reg[SW-2:0], div_ok};
                rem_reg  <= div_ok ? NW'(rem_shift - {1'b0, cnt_reg}) : NW'(rem_shift);
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                lvalid_reg <= (func_reg == svm_pkg::FUNC_TICK) && (cnt_reg != '0);
                level_reg  <= ((func_reg == svm_pkg::FUNC_TICK) && (cnt_reg != '0))
                              ? mean_full[7:0] : 8'd0;
            end
        end
    end

    assign sts.cur_active = act_reg[vi_reg];
    assign sts.last_voice = (32'(vi_reg) == VOICES - 1);
    assign sts.div_done   = (32'(dcnt_reg) == SW) || (cnt_reg == '0);
    assign sts.func       = func_reg;

    assign level_valid = lvalid_reg;
    assign level       = level_reg;
    assign play_status = pst_reg;
    assign done        = done_reg;

endmodule
`default_nettype wire

/* hdl/svm_checker.sv */
`default_nettype none
module svm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       level_valid,
    input wire logic [7:0] level,
    input wire logic [1:0] play_status
);

    // accepted word raises busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // busy is already low while done is high
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy during done");

    // tick and play results never mix
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && level_valid |-> play_status == svm_pkg::PST_NONE) else $error("mixed result");

    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        done && !level_valid |-> level == 8'd0) else $error("stray level");

endmodule

bind sample_voice_mixer_unit svm_checker u_svm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .level_valid (level_valid),
    .level       (level),
    .play_status (play_status)
);
`default_nettype wire

/* tb/sv/tb_sample_voice_mixer_unit.sv */
`timescale 1ns / 1ps
module tb_sample_voice_mixer_unit;

    localparam int NVOICE     = 4;
    localparam int NCLIP      = 16;
    localparam int NSAMPLE    = 4096;
    localparam int TARGET     = 1700;
    localparam int CALM_TAIL  = 300;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 40;

    // One result word as the mixer should present it.
    typedef struct {
        logic                  valid;
        logic [7:0]            level;
        svm_pkg::play_status_t status;
    } mix_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [1:0]  func;
    logic [11:0] mem_addr;
    logic [7:0]  mem_data;
    logic [3:0]  clip_id;
    logic [11:0] clip_start;
    logic [12:0] clip_length;
    logic        level_valid;
    logic [7:0]  level;
    logic [1:0]  play_status;

    // Shadow of the mixer state, updated as each word is accepted.
    logic [7:0]  shadow_samples [NSAMPLE];
    bit          sample_written [NSAMPLE];
    logic [11:0] shadow_start   [NCLIP];
    logic [12:0] shadow_length  [NCLIP];
    bit          clip_defined   [NCLIP];
    bit          voice_on       [NVOICE];
    logic [3:0]  voice_clip_no  [NVOICE];
    logic [11:0] voice_pos      [NVOICE];

    mix_word_t pending_levels [$];
    int        error_count;
    int        words_sent;
    bit        calm;
    int        stall_cycles;

    sample_voice_mixer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .func        (func),
        .mem_addr    (mem_addr),
        .mem_data    (mem_data),
        .clip_id     (clip_id),
        .clip_start  (clip_start),
        .clip_length (clip_length),
        .level_valid (level_valid),
        .level       (level),
        .play_status (play_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the result of one accepted word and advance the shadow state.
    task automatic mix_predict(input svm_pkg::func_t f, input logic [11:0] a,
                               input logic [7:0] d,
                               input logic [3:0] id, input logic [11:0] cs,
                               input logic [12:0] cl);
        mix_word_t w;
        int        sum;
        int        cnt;
        int        len;
        int        c;
        bit        found;
        begin
            w.valid  = 1'b0;
            w.level  = 8'd0;
            w.status = svm_pkg::PST_NONE;
            case (f)
                svm_pkg::FUNC_WRITE:
                begin
                    shadow_samples[a] = d;
                    sample_written[a] = 1'b1;
                end
                svm_pkg::FUNC_DEFINE:
                begin
                    shadow_start[id]  = cs;
                    shadow_length[id] = cl;
                    clip_defined[id]  = 1'b1;
                end
                svm_pkg::FUNC_PLAY:
                begin
                    found = 1'b0;
                    for (int v = 0; v < NVOICE; v++)
                        if (voice_on[v] && voice_clip_no[v] == id)
                            found = 1'b1;
                    if (found)
                        w.status = svm_pkg::PST_PLAYING;
                    else
                    begin
                        w.status = svm_pkg::PST_NO_VOICE;
                        for (int v = 0; v < NVOICE; v++)
                            if (!voice_on[v] && w.status == svm_pkg::PST_NO_VOICE)
                            begin
                                voice_on[v]      = 1'b1;
                                voice_clip_no[v] = id;
                                voice_pos[v]     = 12'd0;
                                w.status         = svm_pkg::PST_STARTED;
                            end
                    end
                end
                default:
                begin
                    sum = 0;
                    cnt = 0;
                    for (int v = 0; v < NVOICE; v++)
                    begin
                        if (voice_on[v])
                        begin
                            c   = voice_clip_no[v];
                            sum += shadow_samples[(shadow_start[c] + voice_pos[v]) % NSAMPLE];
                            cnt++;
                            len = shadow_length[c];
                            if (len == 0)
                                len = 1;
                            if (len > svm_pkg::MAX_CLIP_LEN)
                                len = svm_pkg::MAX_CLIP_LEN;
                            if (voice_pos[v] >= len - 1)
                            begin
                                voice_on[v]  = 1'b0;
                                voice_pos[v] = 12'd0;
                            end
                            else
                                voice_pos[v] = voice_pos[v] + 12'd1;
                        end
                    end
                    if (cnt != 0)
                    begin
                        w.valid = 1'b1;
                        w.level = 8'((sum / cnt) & 8'hFF);
                    end
                end
            endcase
            pending_levels.push_back(w);
        end
    endtask

    // Present one word, hold it until the mixer takes it, then predict.
    task automatic send_word(input svm_pkg::func_t f, input logic [11:0] a,
                             input logic [7:0] d,
                             input logic [3:0] id, input logic [11:0] cs,
                             input logic [12:0] cl);
        begin
            // Idle in a random burst now and then, except in the calm tail.
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            start       <= 1'b1;
            func        <= f;
            mem_addr    <= a;
            mem_data    <= d;
            clip_id     <= id;
            clip_start  <= cs;
            clip_length <= cl;
            // busy only moves at a rising edge, so the falling edge shows
            // what the next rising edge will see.
            do
                @(negedge clk);
            while (busy);
            @(posedge clk);
            mix_predict(f, a, d, id, cs, cl);
            words_sent++;
        end
    endtask

    // Wrappers fill the fields that the function ignores with noise.
    task automatic do_write(input logic [11:0] a, input logic [7:0] d);
        send_word(svm_pkg::FUNC_WRITE, a, d, 4'($urandom), 12'($urandom), 13'($urandom));
    endtask

    task automatic do_define(input logic [3:0] id, input logic [11:0] cs,
                             input logic [12:0] cl);
        send_word(svm_pkg::FUNC_DEFINE, 12'($urandom), 8'($urandom), id, cs, cl);
    endtask

    task automatic do_play(input logic [3:0] id);
        send_word(svm_pkg::FUNC_PLAY, 12'($urandom), 8'($urandom), id, 12'($urandom),
                  13'($urandom));
    endtask

    // A tick reads one sample per active voice: write any such sample that
    // has never been written first, so no undefined byte is ever read.
    task automatic do_tick();
        int addr;
        begin
            for (int v = 0; v < NVOICE; v++)
                if (voice_on[v])
                begin
                    addr = (shadow_start[voice_clip_no[v]] + voice_pos[v]) % NSAMPLE;
                    if (!sample_written[addr])
                        do_write(12'(addr), 8'($urandom));
                end
            send_word(svm_pkg::FUNC_TICK, 12'($urandom), 8'($urandom), 4'($urandom),
                      12'($urandom), 13'($urandom));
        end
    endtask

    // Field extremes, every function and the named corner cases.
    task automatic test_directed();
        begin
            do_tick();                              // no voice active
            do_write(12'd0, 8'd0);
            do_write(12'd4095, 8'd255);
            do_write(12'd1, 8'd128);
            do_define(4'd0, 12'd4095, 13'd3);       // start + position wraps
            do_define(4'd15, 12'd0, 13'd0);         // zero length acts as one
            do_play(4'd0);
            do_play(4'd15);
            do_play(4'd0);                          // already playing
            do_tick();
            do_tick();
            do_tick();
            do_define(4'd3, 12'd2000, 13'd8191);    // long length clamps
            do_define(4'd4, 12'd100, 13'd4096);
            do_define(4'd5, 12'd200, 13'd2);
            do_define(4'd6, 12'd300, 13'd2);
            do_play(4'd3);
            do_play(4'd4);
            do_play(4'd5);
            do_play(4'd6);
            do_play(4'd15);                         // no voice free
            do_tick();
            do_tick();
            do_tick();
            // Shrink clips while they play: each plays one more sample and stops.
            do_define(4'd3, 12'd2000, 13'd1);
            do_define(4'd4, 12'd100, 13'd0);
            do_tick();
            do_tick();
        end
    endtask

    // Well-formed traffic with random content: define, play, tick, plus noise.
    task automatic test_random_traffic();
        int          pick;
        logic [3:0]  id;
        logic [12:0] len;
        begin
            while (words_sent < TARGET)
            begin
                if (words_sent >= TARGET - CALM_TAIL)
                    calm = 1'b1;
                pick = $urandom_range(0, 99);
                id   = 4'($urandom);
                if (pick < 15)
                    do_write(12'($urandom), 8'($urandom));
                else if (pick < 27)
                begin
                    case ($urandom_range(0, 19))
                        0:       len = 13'($urandom);
                        1:       len = 13'd0;
                        default: len = 13'($urandom_range(1, 12));
                    endcase
                    do_define(id, 12'($urandom), len);
                end
                else if (pick < 47)
                begin
                    // Only clips with a table entry may be played.
                    if (!clip_defined[id])
                        do_define(id, 12'($urandom), 13'($urandom_range(0, 12)));
                    do_play(id);
                end
                else
                    do_tick();
            end
        end
    endtask

    // Compare each presented level against the oldest prediction.
    always @(negedge clk)
    begin
        mix_word_t want;
        if (rst_n && done)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected result valid=%0b level=%0d status=%0d",
                         $time, level_valid, level, play_status);
                error_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (level_valid !== want.valid)
                begin
                    $display("%0t: level_valid expected %0b actual %0b",
                             $time, want.valid, level_valid);
                    error_count++;
                end
                if (level !== want.level)
                begin
                    $display("%0t: level expected %0d actual %0d",
                             $time, want.level, level);
                    error_count++;
                end
                if (play_status !== want.status)
                begin
                    $display("%0t: play_status expected %0d actual %0d",
                             $time, want.status, play_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: drop the run when neither side moves for too long.
    always @(negedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        words_sent   = 0;
        calm         = 1'b0;
        stall_cycles = 0;
        for (int v = 0; v < NVOICE; v++)
        begin
            voice_on[v]      = 1'b0;
            voice_clip_no[v] = 4'd0;
            voice_pos[v]     = 12'd0;
        end
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = svm_pkg::FUNC_WRITE;
        mem_addr    = 12'd0;
        mem_data    = 8'd0;
        clip_id     = 4'd0;
        clip_start  = 12'd0;
        clip_length = 13'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();

        start <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
